@@ design/length_prefixed_frame_deframer_macros.svh @@
// ---------------------------------------------------------------------------
// length_prefixed_frame_deframer_macros
// assertion macros shared by the deframer modules; empty under synthesis
// ---------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define LPFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lpfd assertion failed");

// next-cycle implication, checked outside reset
`define LPFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lpfd assertion failed");

`else

`define LPFD_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LPFD_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/lpfd_pkg.sv @@
// ---------------------------------------------------------------------------
// lpfd_pkg
// types and constants shared by the length-prefixed frame deframer
// ---------------------------------------------------------------------------
package lpfd_pkg;

  // header layout
  localparam int HEADER_BYTES = 5;
  localparam int HDR_CNT_W    = $clog2(HEADER_BYTES);
  localparam int BYTE_W       = 8;
  localparam int LEN_W        = 32;
  localparam int OPC_W        = 6;
  localparam int FLAG_BIT     = 7;
  localparam int RSV_BIT      = 6;

  // configuration reset value
  localparam logic [OPC_W-1:0] MAX_OPC_RESET = 6'h3F;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // parser phase
  typedef enum logic {
    PH_HEADER,
    PH_PAYLOAD
  } phase_t;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              has_byte;
    logic [OPC_W-1:0]  frame_opcode;
    logic              frame_error;
    logic              end_of_frame;
  } result_t;

  // front to queue
  typedef struct packed {
    logic    valid;
    result_t data;
  } q_push_t;

  // queue head to back
  typedef struct packed {
    logic    valid;
    result_t data;
  } q_head_t;

endpackage

@@ design/lpfd_front.sv @@
// ---------------------------------------------------------------------------
// lpfd_front
// byte parser: collects the header, checks it, counts the payload down and
// classifies each byte into a result or nothing
// ---------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [lpfd_pkg::OPC_W-1:0]      cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpfd_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic                            q_full,
  output lpfd_pkg::q_push_t               push
);
  import lpfd_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [HDR_CNT_W-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic [BYTE_W-1:0]    hdr_first_r, hdr_first_nxt;
  logic [LEN_W-1:0]     bytes_left_r, bytes_left_nxt;
  logic                 good_r, good_nxt;
  logic [OPC_W-1:0]     max_opc_r;

  logic                 fire;
  logic                 hdr_last;
  logic                 hdr_ok;
  logic [OPC_W-1:0]     opc;
  logic [LEN_W-1:0]     len_shift;
  logic [LEN_W-1:0]     left_dec;
  logic                 len_zero;
  logic                 dec_zero;

  // handshake: room in the queue for any result
  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  // header check and length arithmetic
  assign opc       = hdr_first_r[OPC_W-1:0];
  assign hdr_last  = (hdr_cnt_r == HDR_CNT_W'(HEADER_BYTES - 1));
  assign hdr_ok    = hdr_first_r[FLAG_BIT] && !hdr_first_r[RSV_BIT] &&
                     (opc != '0) && (opc <= max_opc_r);
  assign len_shift = {bytes_left_r[LEN_W-BYTE_W-1:0], in_data_byte};
  assign len_zero  = (len_shift == '0);
  assign left_dec  = bytes_left_r - LEN_W'(1);
  assign dec_zero  = (left_dec == '0);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER: begin
        if (fire && hdr_last && !len_zero) phase_nxt = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (fire && dec_zero) phase_nxt = PH_HEADER;
      end
      default: phase_nxt = PH_HEADER;
    endcase
  end

  // header and counter updates
  always_comb begin
    hdr_cnt_nxt    = hdr_cnt_r;
    hdr_first_nxt  = hdr_first_r;
    bytes_left_nxt = bytes_left_r;
    good_nxt       = good_r;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (hdr_cnt_r == '0) begin
            hdr_first_nxt  = in_data_byte;
            bytes_left_nxt = '0;
            hdr_cnt_nxt    = HDR_CNT_W'(1);
          end else if (hdr_last) begin
            bytes_left_nxt = len_shift;
            hdr_cnt_nxt    = '0;
            good_nxt       = hdr_ok;
          end else begin
            bytes_left_nxt = len_shift;
            hdr_cnt_nxt    = hdr_cnt_r + HDR_CNT_W'(1);
          end
        end
        PH_PAYLOAD: begin
          bytes_left_nxt = left_dec;
        end
        default: hdr_cnt_nxt = '0;
      endcase
    end
  end

  // result classification
  always_comb begin
    push.valid             = 1'b0;
    push.data.payload_byte = '0;
    push.data.has_byte     = 1'b0;
    push.data.frame_opcode = opc;
    push.data.frame_error  = 1'b0;
    push.data.end_of_frame = 1'b0;
    if (fire) begin
      case (phase_r)
        PH_HEADER: begin
          // empty frame closes on its last header byte
          if (hdr_last && len_zero) begin
            push.valid             = 1'b1;
            push.data.frame_error  = !hdr_ok;
            push.data.end_of_frame = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          if (good_r) begin
            push.valid             = 1'b1;
            push.data.payload_byte = in_data_byte;
            push.data.has_byte     = 1'b1;
            push.data.end_of_frame = dec_zero;
          end else if (dec_zero) begin
            push.valid             = 1'b1;
            push.data.frame_error  = 1'b1;
            push.data.end_of_frame = 1'b1;
          end
        end
        default: push.valid = 1'b0;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      hdr_cnt_r    <= '0;
      hdr_first_r  <= '0;
      bytes_left_r <= '0;
      good_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      hdr_first_r  <= hdr_first_nxt;
      bytes_left_r <= bytes_left_nxt;
      good_r       <= good_nxt;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_opc_r <= MAX_OPC_RESET;
    end else if (cfg_wr_en) begin
      max_opc_r <= cfg_wr_data;
    end
  end

  `LPFD_ASSERT_IMP(a_payload_len_nonzero, clk, rst_n, phase_r == PH_PAYLOAD, bytes_left_r != '0)
  `LPFD_ASSERT_IMP(a_hdr_cnt_in_range, clk, rst_n, phase_r == PH_PAYLOAD, hdr_cnt_r == '0)

endmodule

@@ design/lpfd_queue.sv @@
// ---------------------------------------------------------------------------
// lpfd_queue
// short result queue between parser and output stage
// ---------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  lpfd_pkg::q_push_t push,
  output logic              full,
  output lpfd_pkg::q_head_t head,
  input  logic              pop
);
  import lpfd_pkg::*;

  result_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.data  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.data;
  end

  `LPFD_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push.valid, !full)
  `LPFD_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop, head.valid)

endmodule

@@ design/lpfd_back.sv @@
// ---------------------------------------------------------------------------
// lpfd_back
// output stage: takes results from the queue head into the output register
// ---------------------------------------------------------------------------
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lpfd_pkg::q_head_t           head,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpfd_pkg::BYTE_W-1:0] out_payload_byte,
  output logic                        out_has_byte,
  output logic [lpfd_pkg::OPC_W-1:0]  out_frame_opcode,
  output logic                        out_frame_error,
  output logic                        out_end_of_frame
);
  import lpfd_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;

  // load when the register is empty or being drained
  assign pop = head.valid && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_data_r <= head.data;
  end

  // port fan-out
  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_data_r.payload_byte;
  assign out_has_byte     = out_data_r.has_byte;
  assign out_frame_opcode = out_data_r.frame_opcode;
  assign out_frame_error  = out_data_r.frame_error;
  assign out_end_of_frame = out_data_r.end_of_frame;

  `LPFD_ASSERT_NXT(a_back_load_shows, clk, rst_n, pop, out_valid_r)

endmodule

@@ design/length_prefixed_frame_deframer.sv @@
// ---------------------------------------------------------------------------
// length_prefixed_frame_deframer
// splits a byte stream into length-prefixed frames and emits payload bytes
// ---------------------------------------------------------------------------
// The block gives at most one result per stream byte; a result passes through
// the result queue and the output register to the out_ channel. Input is
// accepted whenever the four-entry result queue has room, so the rate is one
// byte per cycle for as long as the output side takes results; under output
// backpressure the queue fills and in_ready drops. Header bytes and rejected
// payload bytes give no result, save the last byte of an empty frame's header
// and of a rejected frame, which end the frame. cfg_wr_data sets the largest
// accepted opcode (reset 63) and takes effect at the next header check.

module length_prefixed_frame_deframer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [lpfd_pkg::OPC_W-1:0]  cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lpfd_pkg::BYTE_W-1:0] in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lpfd_pkg::BYTE_W-1:0] out_payload_byte,
  output logic                        out_has_byte,
  output logic [lpfd_pkg::OPC_W-1:0]  out_frame_opcode,
  output logic                        out_frame_error,
  output logic                        out_end_of_frame
);
  import lpfd_pkg::*;

  q_push_t push;
  q_head_t head;
  logic    q_full;
  logic    pop;

  // parser
  lpfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .push         (push)
  );

  // result queue
  lpfd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  // output stage
  lpfd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_has_byte     (out_has_byte),
    .out_frame_opcode (out_frame_opcode),
    .out_frame_error  (out_frame_error),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule
